// ===== rtl/decimal_bcd_alu_assert.svh =====
`ifndef DECIMAL_BCD_ALU_ASSERT_SVH
`define DECIMAL_BCD_ALU_ASSERT_SVH
// implication checked on every clock edge outside reset
`define DBA_ASSERT_IMP(lbl, clk, rst_n, lhs, rhs) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
		else $error("assertion failed");
// implication whose consequent is checked in the next cycle
`define DBA_ASSERT_NEXT(lbl, clk, rst_n, lhs, rhs) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
		else $error("assertion failed");
`endif

// ===== rtl/dba_pkg.sv =====
package dba_pkg;
	localparam int MAX_DIGITS = 16;
	localparam logic [2:0] OP_ADD = 3'd0;
	localparam logic [2:0] OP_SUB = 3'd1;
	localparam logic [2:0] OP_MUL = 3'd2;
	localparam logic [2:0] OP_DIV = 3'd3;
	localparam logic [2:0] OP_CMP = 3'd4;
	localparam logic [1:0] REL_LT = 2'd0;
	localparam logic [1:0] REL_EQ = 2'd1;
	localparam logic [1:0] REL_GT = 2'd2;

	// one decimal digit step of the shared adder
	typedef struct packed {
		logic [3:0] dig;
		logic       carry;
	} dstep_t;

	function automatic logic [3:0] clamp_digit(input logic [3:0] n);
		clamp_digit = (n > 4'd9) ? 4'd9 : n;
	endfunction
endpackage

// ===== rtl/decimal_bcd_alu.sv =====
// channel | ports                                          | handshake
// in      | operation, operand_a, operand_b               | start & !busy
// out     | value, relation, overflow, error              | done strobe
// all operations run one decimal digit per cycle through one digit adder/subtractor.
// add, subtract, compare: one pass over DIGITS+1 digits; unknown operation: straight to output.
// multiply: up to 9 adds of DIGITS+1 digit steps per multiplier digit.
// divide: up to 10 trial subtracts per quotient digit.
// reset clears the sequencer; done pulses one cycle and the receiver cannot stall.
`include "decimal_bcd_alu_assert.svh"
module decimal_bcd_alu #(
	parameter int DIGITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  operation,
	input  logic [63:0] operand_a,
	input  logic [63:0] operand_b,
	output logic        done,
	output logic [63:0] value,
	output logic [1:0]  relation,
	output logic        overflow,
	output logic        error
);
	localparam int ND = DIGITS + 1;        // working width with one guard digit
	localparam int DW = $clog2(ND + 1);
	localparam int W  = 4 * ND;

	typedef enum logic [3:0] {
		S_IDLE, S_SUB, S_SUBCHK, S_ADDCHK,
		S_MSEL, S_MADD, S_MNEXT,
		S_DSHIFT, S_DTRY, S_DCHK, S_DDONE, S_OUT
	} state_t;

	state_t     state_q;
	logic [2:0] op_q;
	logic [W-1:0] a_q, b_q, acc_q, tmp_q, mq_q;
	logic [3:0] cnt_q;                     // current multiplier digit / trial count
	logic [DW-1:0] di_q, pos_q;
	logic       cy_q, ovf_q;
	logic [63:0] value_q;
	logic [1:0]  rel_q;
	logic        err_q;
	logic        zero_b_q;

	dba_pkg::dstep_t du;
	logic du_sub;
	logic [3:0] du_x, du_y;
	logic [W-1:0] a_in, b_in;

	always_comb begin
		a_in = '0;
		b_in = '0;
		for (int i = 0; i < DIGITS; i++) begin
			a_in[4*i +: 4] = dba_pkg::clamp_digit(operand_a[4*i +: 4]);
			b_in[4*i +: 4] = dba_pkg::clamp_digit(operand_b[4*i +: 4]);
		end
	end

	// operand selection for the shared digit unit
	always_comb begin
		du_sub = 1'b1;
		du_x = acc_q[4*di_q[DW-1:0] +: 4];
		du_y = b_q[4*di_q +: 4];
		case (state_q)
			S_SUB: begin
				du_sub = (op_q != dba_pkg::OP_ADD);
				du_x = a_q[4*di_q +: 4];
			end
			S_MADD: du_sub = 1'b0;
			default: du_sub = 1'b1;
		endcase
	end

	dba_digit_unit u_du (.sub(du_sub), .x(du_x), .y(du_y), .cin(cy_q), .res(du));

	logic last_d;
	assign last_d = (di_q == DW'(ND - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done <= 1'b0;
			op_q <= dba_pkg::OP_ADD;
			a_q <= '0;
			b_q <= '0;
			zero_b_q <= 1'b0;
			acc_q <= '0;
			tmp_q <= '0;
			mq_q <= '0;
			di_q <= '0;
			cy_q <= 1'b0;
			ovf_q <= 1'b0;
			err_q <= 1'b0;
			rel_q <= dba_pkg::REL_LT;
			value_q <= '0;
			cnt_q <= '0;
			pos_q <= '0;
		end else begin
			done <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						op_q <= operation;
						a_q <= a_in;
						b_q <= b_in;
						zero_b_q <= (b_in == '0);
						acc_q <= '0;
						tmp_q <= '0;
						mq_q <= '0;
						di_q <= '0;
						cy_q <= 1'b0;
						ovf_q <= 1'b0;
						err_q <= 1'b0;
						rel_q <= dba_pkg::REL_LT;
						value_q <= '0;
						cnt_q <= '0;
						pos_q <= DW'(DIGITS - 1);
						case (operation)
							dba_pkg::OP_ADD, dba_pkg::OP_SUB, dba_pkg::OP_CMP:
								state_q <= S_SUB;
							dba_pkg::OP_MUL: state_q <= S_MSEL;
							dba_pkg::OP_DIV: state_q <= S_DSHIFT;
							default: state_q <= S_OUT;
						endcase
					end
				end
				S_SUB: begin
					acc_q[4*di_q +: 4] <= du.dig;
					cy_q <= du.carry;
					di_q <= di_q + 1'b1;
					if (last_d) state_q <= S_SUBCHK;
				end
				S_SUBCHK: begin
					// cy_q is the final borrow for sub/cmp
					case (op_q)
						dba_pkg::OP_ADD: begin
							ovf_q <= (acc_q[W-1 -: 4] != 4'd0);
							value_q <= 64'(acc_q[4*DIGITS-1:0]);
						end
						dba_pkg::OP_SUB: begin
							if (cy_q) err_q <= 1'b1;
							else value_q <= 64'(acc_q[4*DIGITS-1:0]);
						end
						default: begin
							if (cy_q) rel_q <= dba_pkg::REL_LT;
							else if (acc_q == '0) rel_q <= dba_pkg::REL_EQ;
							else rel_q <= dba_pkg::REL_GT;
						end
					endcase
					state_q <= S_OUT;
				end
				// multiply: process a digits from the top, acc = acc*10 + b*digit
				S_MSEL: begin
					if (acc_q[W-1 -: 4] != 4'd0) ovf_q <= 1'b1;
					acc_q <= {acc_q[W-5:0], 4'd0};
					cnt_q <= a_q[4*pos_q +: 4];
					di_q <= '0;
					cy_q <= 1'b0;
					state_q <= (a_q[4*pos_q +: 4] == 4'd0) ? S_MNEXT : S_MADD;
				end
				S_MADD: begin
					acc_q[4*di_q +: 4] <= du.dig;
					cy_q <= du.carry;
					di_q <= di_q + 1'b1;
					if (last_d) begin
						if (du.carry) ovf_q <= 1'b1;
						di_q <= '0;
						cy_q <= 1'b0;
						cnt_q <= cnt_q - 1'b1;
						if (cnt_q == 4'd1) state_q <= S_MNEXT;
					end
				end
				S_MNEXT: begin
					if (pos_q == '0) begin
						ovf_q <= ovf_q | (acc_q[W-1 -: 4] != 4'd0);
						value_q <= 64'(acc_q[4*DIGITS-1:0]);
						state_q <= S_OUT;
					end else begin
						pos_q <= pos_q - 1'b1;
						state_q <= S_MSEL;
					end
				end
				// divide: remainder in acc, quotient in mq
				S_DSHIFT: begin
					if (zero_b_q) begin
						err_q <= 1'b1;
						state_q <= S_OUT;
					end else begin
						acc_q <= {acc_q[W-5:0], a_q[4*pos_q +: 4]};
						cnt_q <= '0;
						di_q <= '0;
						cy_q <= 1'b0;
						state_q <= S_DTRY;
					end
				end
				S_DTRY: begin
					tmp_q[4*di_q +: 4] <= du.dig;
					cy_q <= du.carry;
					di_q <= di_q + 1'b1;
					if (last_d) state_q <= S_DCHK;
				end
				S_DCHK: begin
					di_q <= '0;
					cy_q <= 1'b0;
					if (!cy_q) begin
						acc_q <= tmp_q;
						cnt_q <= cnt_q + 1'b1;
						state_q <= S_DTRY;
					end else begin
						state_q <= S_DDONE;
					end
				end
				S_DDONE: begin
					mq_q <= {mq_q[W-5:0], cnt_q};
					if (pos_q == '0) begin
						// quotient holds DIGITS digits, the guard digit is zero
						value_q <= 64'({mq_q[W-5:0], cnt_q});
						state_q <= S_OUT;
					end else begin
						pos_q <= pos_q - 1'b1;
						state_q <= S_DSHIFT;
					end
				end
				S_OUT: begin
					done <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy = (state_q != S_IDLE);
	assign value = value_q;
	assign relation = rel_q;
	assign overflow = ovf_q;
	assign error = err_q;

	`DBA_ASSERT_IMP(a_done_idle, clk, arst_n, done, !busy)
	`DBA_ASSERT_IMP(a_err_zero, clk, arst_n, done && error, value == 64'd0)
	`DBA_ASSERT_NEXT(a_out_done, clk, arst_n, state_q == S_OUT, done)
	`DBA_ASSERT_IMP(a_ovf_err, clk, arst_n, done && overflow, !error)
endmodule

// ===== rtl/dba_digit_unit.sv =====
// shared digit unit: one BCD digit add or subtract with carry/borrow
module dba_digit_unit (
	input  logic           sub,
	input  logic [3:0]     x,
	input  logic [3:0]     y,
	input  logic           cin,
	output dba_pkg::dstep_t res
);
	logic [4:0] t;
	always_comb begin
		res = '0;
		if (sub) begin
			t = {1'b0, x} - {1'b0, y} - {4'd0, cin};
			if (t[4]) begin
				res.dig = 4'(t[3:0] + 4'd10);
				res.carry = 1'b1;
			end else begin
				res.dig = t[3:0];
				res.carry = 1'b0;
			end
		end else begin
			t = {1'b0, x} + {1'b0, y} + {4'd0, cin};
			if (t > 5'd9) begin
				res.dig = 4'(t - 5'd10);
				res.carry = 1'b1;
			end else begin
				res.dig = t[3:0];
				res.carry = 1'b0;
			end
		end
	end
endmodule

// ===== tb/sv/decimal_bcd_alu_checker.sv =====
`timescale 1ns / 1ps
module decimal_bcd_alu_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  logic [2:0]  operation,
	input  logic [63:0] operand_a,
	input  logic [63:0] operand_b,
	input  logic        done,
	input  logic [63:0] value,
	input  logic [1:0]  relation,
	input  logic        overflow,
	input  logic        error,
	output int          fail_count,
	output int          pending
);
	localparam logic [63:0] DEC_LIMIT = 64'd10000000000000000;

	typedef struct packed {
		logic [63:0] value;
		logic [1:0]  relation;
		logic        overflow;
		logic        error;
	} alu_result_t;

	alu_result_t result_q[$];

	function automatic logic [63:0] bcd_to_int(input logic [63:0] x);
		logic [63:0] v;
		v = 0;
		for (int i = dba_pkg::MAX_DIGITS - 1; i >= 0; i--)
			v = v * 10 + ((x[4*i +: 4] > 4'd9) ? 64'd9 : 64'(x[4*i +: 4]));
		return v;
	endfunction

	function automatic logic [63:0] int_to_bcd(input logic [63:0] v);
		logic [63:0] r;
		r = 0;
		for (int i = 0; i < dba_pkg::MAX_DIGITS; i++) begin
			r[4*i +: 4] = 4'(v % 10);
			v = v / 10;
		end
		return r;
	endfunction

	function automatic alu_result_t compute_result(input logic [2:0] op,
			input logic [63:0] a_bcd, input logic [63:0] b_bcd);
		alu_result_t r;
		logic [63:0] a, b;
		logic [127:0] prod;
		r = '0;
		a = bcd_to_int(a_bcd);
		b = bcd_to_int(b_bcd);
		case (op)
			dba_pkg::OP_ADD: begin
				r.overflow = (a + b) >= DEC_LIMIT;
				r.value = int_to_bcd(r.overflow ? a + b - DEC_LIMIT : a + b);
			end
			dba_pkg::OP_SUB: begin
				if (a < b)
					r.error = 1'b1;
				else
					r.value = int_to_bcd(a - b);
			end
			dba_pkg::OP_MUL: begin
				prod = 128'(a) * 128'(b);
				r.overflow = prod >= 128'(DEC_LIMIT);
				r.value = int_to_bcd(64'(prod % 128'(DEC_LIMIT)));
			end
			dba_pkg::OP_DIV: begin
				if (b == 0)
					r.error = 1'b1;
				else
					r.value = int_to_bcd(a / b);
			end
			dba_pkg::OP_CMP: r.relation = (a < b) ? dba_pkg::REL_LT
				: ((a == b) ? dba_pkg::REL_EQ : dba_pkg::REL_GT);
			default: ;
		endcase
		return r;
	endfunction

	task automatic report(input string msg);
		$display("mismatch at %0t: %s", $time, msg);
		fail_count++;
	endtask

	initial fail_count = 0;
	assign pending = result_q.size();

	always @(posedge clk) begin
		alu_result_t want;
		if (arst_n) begin
			// result of an earlier item is checked before the new item is queued
			if (done) begin
				if (result_q.size() == 0) begin
					report("result with no item outstanding");
				end else begin
					want = result_q.pop_front();
					if (value !== want.value)
						report($sformatf("value %h, want %h", value, want.value));
					if (relation !== want.relation)
						report($sformatf("relation %0d, want %0d", relation, want.relation));
					if (overflow !== want.overflow)
						report($sformatf("overflow %b, want %b", overflow, want.overflow));
					if (error !== want.error)
						report($sformatf("error %b, want %b", error, want.error));
				end
			end
			if (start && !busy)
				result_q.push_back(compute_result(operation, operand_a, operand_b));
		end
	end
endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
module tb;
	localparam int RANDOM_ITEMS = 1930;
	localparam int CALM_TAIL = 300;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic [2:0]  operation = dba_pkg::OP_ADD;
	logic [63:0] operand_a = '0;
	logic [63:0] operand_b = '0;
	logic        done;
	logic [63:0] value;
	logic [1:0]  relation;
	logic        overflow;
	logic        error;
	int          fail_count;
	int          pending;

	always #5 clk = ~clk;

	decimal_bcd_alu i_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.operation(operation), .operand_a(operand_a), .operand_b(operand_b),
		.done(done), .value(value), .relation(relation),
		.overflow(overflow), .error(error)
	);

	decimal_bcd_alu_checker i_checker (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.operation(operation), .operand_a(operand_a), .operand_b(operand_b),
		.done(done), .value(value), .relation(relation),
		.overflow(overflow), .error(error),
		.fail_count(fail_count), .pending(pending)
	);

	// called at a falling edge; returns at the falling edge after acceptance
	task automatic issue(input logic [2:0] op, input logic [63:0] a, input logic [63:0] b);
		logic taken;
		start <= 1'b1;
		operation <= op;
		operand_a <= a;
		operand_b <= b;
		taken = 1'b0;
		while (!taken) begin
			@(posedge clk);
			taken = !busy;
			@(negedge clk);
		end
	endtask

	task automatic pause(input int cycles);
		start <= 1'b0;
		repeat (cycles) @(negedge clk);
	endtask

	// ndig low digits filled, an invalid nibble now and then
	function automatic logic [63:0] rand_bcd(input int ndig);
		logic [63:0] x;
		x = '0;
		for (int i = 0; i < ndig; i++)
			x[4*i +: 4] = ($urandom_range(0, 15) == 0) ? 4'($urandom_range(10, 15))
				: 4'($urandom_range(0, 9));
		return x;
	endfunction

	function automatic int rand_len();
		return ($urandom_range(0, 9) < 8) ? $urandom_range(1, 6) : $urandom_range(7, 16);
	endfunction

	initial begin
		automatic logic [63:0] all_nines = 64'h9999_9999_9999_9999;
		logic [2:0] op;
		logic [63:0] a, b;
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		issue(dba_pkg::OP_ADD, all_nines, 64'h1);
		issue(dba_pkg::OP_ADD, 64'h0, 64'h0);
		issue(dba_pkg::OP_ADD, '1, '1);
		issue(dba_pkg::OP_SUB, 64'h1234, 64'h1234);
		issue(dba_pkg::OP_SUB, 64'h5, 64'h6);
		issue(dba_pkg::OP_SUB, all_nines, 64'h0);
		issue(dba_pkg::OP_SUB, '1, 64'h1);
		issue(dba_pkg::OP_MUL, all_nines, all_nines);
		issue(dba_pkg::OP_MUL, 64'h0, '1);
		issue(dba_pkg::OP_MUL, 64'h1_0000_0000, 64'h1_0000_0000);
		issue(dba_pkg::OP_MUL, 64'h12, 64'h34);
		issue(dba_pkg::OP_DIV, all_nines, 64'h0);
		issue(dba_pkg::OP_DIV, 64'h7, 64'h8);
		issue(dba_pkg::OP_DIV, all_nines, 64'h3);
		issue(dba_pkg::OP_DIV, '1, 64'hA);
		issue(dba_pkg::OP_CMP, 64'h3, 64'h4);
		issue(dba_pkg::OP_CMP, 64'hF, 64'h9);
		issue(dba_pkg::OP_CMP, all_nines, 64'h1);
		issue(3'd5, all_nines, all_nines);
		issue(3'd6, 64'h1, 64'h2);
		issue(3'd7, '1, '1);

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			op = ($urandom_range(0, 31) == 0) ? 3'($urandom_range(5, 7))
				: 3'($urandom_range(0, 4));
			a = rand_bcd(rand_len());
			b = rand_bcd(rand_len());
			case ($urandom_range(0, 7))
				0: b = a;
				1: b = '0;
				2: a = '1;
				default: ;
			endcase
			if (n < RANDOM_ITEMS - CALM_TAIL && $urandom_range(0, 3) == 0)
				pause($urandom_range(1, 16));
			issue(op, a, b);
		end
		start <= 1'b0;

		while (pending != 0) @(negedge clk);
		repeat (50) @(negedge clk);
		if (fail_count == 0 && pending == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	initial begin
		#500ms;
		$display("TB_ERROR");
		$finish;
	end
endmodule

// ===== files.f =====
+incdir+rtl
rtl/dba_pkg.sv
rtl/dba_digit_unit.sv
rtl/decimal_bcd_alu.sv
tb/sv/decimal_bcd_alu_checker.sv
tb/sv/tb.sv
